FILE: design/mmcrc_pkg.sv
`timescale 1ns / 1ps

package mmcrc_pkg;

   // csr_crc_mode codes; the unused code runs as CRC-32
   localparam logic [1:0] CSR_MODE_CRC32   = 2'd0;
   localparam logic [1:0] CSR_MODE_CRC32P4 = 2'd1;
   localparam logic [1:0] CSR_MODE_CRC16   = 2'd2;

   localparam logic [31:0] CRC32_REFL_POLY   = 32'hEDB88320;
   localparam logic [31:0] CRC32P4_REFL_POLY = 32'hC8DF352F;
   localparam logic [15:0] CRC16_POLY        = 16'h1021;
   localparam logic [31:0] CRC32_INIT        = 32'hFFFFFFFF;
   localparam logic [31:0] CRC32_XOROUT      = 32'hFFFFFFFF;
   localparam logic [15:0] CRC16_INIT        = 16'hFFFF;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_CRC32,
      KIND_CRC32P4,
      KIND_CRC16
   } crc_kind_type;

   typedef struct packed {
      crc_kind_type kind;
      logic         load;
      logic [31:0]  load_value;
      logic         present;
      logic [7:0]   data_byte;
      logic         last;
   } crc_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic logic [31:0] fold_reflected(input logic [31:0] crc,
                                                  input logic [7:0]  data,
                                                  input logic [31:0] poly);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) c = (c >> 1) ^ poly;
         else      c = c >> 1;
      end
      return c;
   endfunction

   function automatic logic [15:0] fold_ccitt(input logic [15:0] crc,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'd0};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) c = (c << 1) ^ CRC16_POLY;
         else       c = c << 1;
      end
      return c;
   endfunction

endpackage

FILE: design/multi_mode_crc_engine.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// req       in   tvalid/tready      tdata {seed_value, data_byte}, tuser flags, tlast = last
// rsp       out  tvalid/tready      tdata crc_result
// csr       in   wr_en              wr_data = crc_mode
// One request a cycle enters the queue while it has room; the back end folds one byte a
// cycle with an 8-step XOR tree per mode, so throughput is one request per clock while
// results are taken. A last request is queued first; its result is registered as it pops.
// A stalled result only holds back requests carrying last; the queue absorbs the rest.
// Synchronous reset clears the queue, the running CRC and the mode (CRC-32).

module multi_mode_crc_engine import mmcrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] data_byte, [39:8] seed_value
   input  logic [2:0]  req_tuser,   // [0] byte_present, [1] start_req, [2] fresh_start
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] crc_result
);

   logic            push;
   logic            pop;
   crc_entry_type   push_entry;
   crc_entry_type   head_entry;
   fifo_status_type fifo_status;

   mmcrc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .fifo_full  (fifo_status.full),
      .push       (push),
      .push_entry (push_entry)
   );

   mmcrc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head_entry(head_entry),
      .status    (fifo_status)
   );

   mmcrc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .fifo_empty(fifo_status.empty),
      .head_entry(head_entry),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      !(fifo_status.full && fifo_status.empty))
      else $error("queue reports full and empty at once");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_status.empty)
      else $error("pop from empty queue");

   assert property (@(posedge clock) disable iff (reset)
      (pop && head_entry.last) |=> rsp_tvalid)
      else $error("last request popped without a result");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !(pop && head_entry.last))
      else $error("result overwritten while stalled");
`endif

endmodule

FILE: design/mmcrc_front.sv
`timescale 1ns / 1ps

module mmcrc_front import mmcrc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [1:0]    csr_wr_data,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [39:0]   req_tdata,
   input  logic [2:0]    req_tuser,
   input  logic          req_tlast,
   input  logic          fifo_full,
   output logic          push,
   output crc_entry_type push_entry
);

   logic [1:0]   crc_mode_ff;
   crc_kind_type kind;
   logic         fresh;
   logic [31:0]  seed;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_mode_ff <= CSR_MODE_CRC32;
      end else if (csr_wr_en) begin
         crc_mode_ff <= csr_wr_data;
      end
   end

   always_comb begin
      unique case (crc_mode_ff)
         CSR_MODE_CRC32P4: kind = KIND_CRC32P4;
         CSR_MODE_CRC16:   kind = KIND_CRC16;
         default:          kind = KIND_CRC32;
      endcase
   end

   assign fresh = req_tuser[2];
   assign seed  = req_tdata[39:8];

   always_comb begin
      push_entry.kind      = kind;
      push_entry.load      = req_tuser[1];
      push_entry.present   = req_tuser[0];
      push_entry.data_byte = req_tdata[7:0];
      push_entry.last      = req_tlast;
      // resume values are un-finalised here so the back end only ever folds
      if (kind == KIND_CRC16) begin
         push_entry.load_value = fresh ? {16'd0, CRC16_INIT} : {16'd0, seed[15:0]};
      end else begin
         push_entry.load_value = fresh ? CRC32_INIT : (seed ^ CRC32_XOROUT);
      end
   end

   assign req_tready = !fifo_full;
   assign push       = req_tvalid && !fifo_full;

endmodule

FILE: design/mmcrc_fifo.sv
`timescale 1ns / 1ps

module mmcrc_fifo import mmcrc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  crc_entry_type   push_entry,
   input  logic            pop,
   output crc_entry_type   head_entry,
   output fifo_status_type status
);

   crc_entry_type        mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   count_ff,  count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + FIFO_CW'(1);
      if (pop && !push) count_in = count_ff - FIFO_CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head_entry   = mem[rd_ptr_ff];
   assign status.full  = (count_ff == FIFO_CW'(FIFO_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

FILE: design/mmcrc_back.sv
`timescale 1ns / 1ps

module mmcrc_back import mmcrc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          fifo_empty,
   input  crc_entry_type head_entry,
   output logic          pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata
);

   logic [31:0] running_crc_ff, running_crc_in;
   logic        rsp_valid_ff,   rsp_valid_in;
   logic [31:0] rsp_data_ff,    rsp_data_in;
   logic [31:0] base;
   logic        out_free;

   // a request without last never touches the output register, so it need not wait
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign pop      = !fifo_empty && (!head_entry.last || out_free);

   always_comb begin
      base = head_entry.load ? head_entry.load_value : running_crc_ff;
      if (head_entry.kind == KIND_CRC16) base = {16'd0, base[15:0]};

      running_crc_in = base;
      if (head_entry.present) begin
         case (head_entry.kind)
            KIND_CRC16:   running_crc_in = {16'd0, fold_ccitt(base[15:0], head_entry.data_byte)};
            KIND_CRC32P4: running_crc_in = fold_reflected(base, head_entry.data_byte,
                                                          CRC32P4_REFL_POLY);
            default:      running_crc_in = fold_reflected(base, head_entry.data_byte,
                                                          CRC32_REFL_POLY);
         endcase
      end

      rsp_data_in  = (head_entry.kind == KIND_CRC16) ? running_crc_in
                                                     : running_crc_in ^ CRC32_XOROUT;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (pop && head_entry.last) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (pop) running_crc_ff <= running_crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_entry.last) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: sim/multi_mode_crc_engine_checker.sv
`timescale 1ns / 1ps

module multi_mode_crc_engine_checker import mmcrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] data_byte, [39:8] seed_value
   input  logic [2:0]  req_tuser,   // [0] byte_present, [1] start_req, [2] fresh_start
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [31:0] crc_result
   output int          fail_count,
   output int          pending_results,
   output int          results_checked
);

   typedef struct packed {
      logic [31:0] seed_value;
      logic        fresh_start;
      logic        start_req;
      logic        byte_present;
      logic [7:0]  data_byte;
      logic        is_last;
   } crc_request_type;

   logic [1:0]  crc_mode_q;
   logic [31:0] running_crc_q;
   logic [31:0] expected_crc_q[$];
   logic [31:0] expected_crc;
   crc_request_type req;

   // One byte through the shift register, bit by bit; mode 3 runs as CRC-32
   function automatic logic [31:0] crc_fold_byte(input logic [1:0]  mode,
                                                 input logic [31:0] crc,
                                                 input logic [7:0]  data);
      logic [31:0] r;
      logic [31:0] poly;
      int          k;
      if (mode == CSR_MODE_CRC16) begin
         r = {16'd0, crc[15:0] ^ {data, 8'd0}};
         for (k = 0; k < 8; k++) begin
            if (r[15]) r = {16'd0, r[14:0], 1'b0} ^ {16'd0, CRC16_POLY};
            else       r = {16'd0, r[14:0], 1'b0};
         end
      end else begin
         poly = (mode == CSR_MODE_CRC32P4) ? CRC32P4_REFL_POLY : CRC32_REFL_POLY;
         r = crc ^ {24'd0, data};
         for (k = 0; k < 8; k++)
            r = {1'b0, r[31:1]} ^ (r[0] ? poly : 32'd0);
      end
      return r;
   endfunction

   task automatic predict_crc(input crc_request_type rq);
      logic is16;
      is16 = (crc_mode_q == CSR_MODE_CRC16);
      if (rq.start_req) begin
         if (is16)
            running_crc_q = rq.fresh_start ? {16'd0, CRC16_INIT} : {16'd0, rq.seed_value[15:0]};
         else
            running_crc_q = rq.fresh_start ? CRC32_INIT : rq.seed_value ^ CRC32_XOROUT;
      end
      // entering CRC-16 cuts whatever is left from a 32-bit mode
      if (is16)
         running_crc_q[31:16] = 16'd0;
      if (rq.byte_present)
         running_crc_q = crc_fold_byte(crc_mode_q, running_crc_q, rq.data_byte);
      if (rq.is_last)
         expected_crc_q.push_back(is16 ? {16'd0, running_crc_q[15:0]}
                                       : running_crc_q ^ CRC32_XOROUT);
   endtask

   initial begin
      fail_count      = 0;
      pending_results = 0;
      results_checked = 0;
      crc_mode_q      = CSR_MODE_CRC32;
      running_crc_q   = 32'd0;
   end

   always @(posedge clock) begin
      if (reset) begin
         crc_mode_q    = CSR_MODE_CRC32;
         running_crc_q = 32'd0;
         expected_crc_q.delete();
      end else begin
         // compare before predicting so a result never meets its own request
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (expected_crc_q.size() == 0) begin
               fail_count++;
               $display("%0t: crc_result expected none, got %08h", $time, rsp_tdata);
            end else begin
               expected_crc = expected_crc_q.pop_front();
               if (rsp_tdata !== expected_crc) begin
                  fail_count++;
                  $display("%0t: crc_result expected %08h, got %08h",
                           $time, expected_crc, rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            req.seed_value   = req_tdata[39:8];
            req.data_byte    = req_tdata[7:0];
            req.byte_present = req_tuser[0];
            req.start_req    = req_tuser[1];
            req.fresh_start  = req_tuser[2];
            req.is_last      = req_tlast;
            predict_crc(req);
         end
         if (csr_wr_en)
            crc_mode_q = csr_wr_data;
      end
      pending_results = expected_crc_q.size();
   end

endmodule

FILE: sim/multi_mode_crc_engine_test.sv
`timescale 1ns / 1ps

module multi_mode_crc_engine_test import mmcrc_pkg::*;;

   localparam logic [1:0] CSR_MODE_SPARE = 2'd3;   // undefined code, runs as CRC-32
   localparam int DRAIN_CYCLES   = 12;
   localparam int LIMIT_CYCLES   = 400000;
   localparam int RANDOM_ITEMS   = 1600;
   localparam int SEGMENTS       = 6;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [1:0]  csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;

   int fail_count;
   int pending_results;
   int results_checked;
   int requests_sent;
   int req_idle_pct;
   int rsp_idle_pct;
   int cycle_count;

   logic [1:0] segment_mode[SEGMENTS] = '{CSR_MODE_CRC32, CSR_MODE_CRC16, CSR_MODE_CRC32P4,
                                          CSR_MODE_SPARE, CSR_MODE_CRC16, CSR_MODE_CRC32P4};

   multi_mode_crc_engine u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   multi_mode_crc_engine_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .results_checked (results_checked)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("multi_mode_crc_engine: mismatch");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance with
   // tvalid still high, so the next request or an idle takes one assignment.
   task automatic send_request(input logic [7:0]  data,
                               input logic        present,
                               input logic        start,
                               input logic        fresh,
                               input logic [31:0] seed,
                               input logic        is_last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {seed, data};
      req_tuser  <= {fresh, start, present};
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      @(negedge clock);
   endtask

   // Let every expected result out, then allow the queue to empty of non-last requests
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(input logic [1:0] mode);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_message();
      int          len;
      int          k;
      logic        fresh;
      logic [31:0] seed;
      fresh = 1'($urandom_range(1));
      seed  = $urandom;
      if ($urandom_range(15) == 0)
         len = 0;
      else if ($urandom_range(7) == 0)
         len = $urandom_range(64, 17);
      else
         len = $urandom_range(16, 1);
      if (len == 0) begin
         send_request(8'($urandom_range(255)), 1'b0, 1'b1, fresh, seed, 1'b1);
      end else begin
         for (k = 0; k < len; k++) begin
            // ignored fields on follow-on requests still carry random values
            send_request(8'($urandom_range(255)), ($urandom_range(19) != 0),
                         (k == 0), (k == 0) ? fresh : 1'($urandom_range(1)),
                         (k == 0) ? seed : 32'($urandom), (k == len - 1));
         end
      end
   endtask

   initial begin
      int seg;
      int target;
      cycle_count   = 0;
      requests_sent = 0;
      req_idle_pct  = 0;
      rsp_idle_pct  = 0;
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = CSR_MODE_CRC32;
      req_tvalid    = 1'b0;
      req_tdata     = 40'd0;
      req_tuser     = 3'd0;
      req_tlast     = 1'b0;
      rsp_tready    = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fold without start from the zero left by reset
      send_request(8'hFF, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1);
      write_mode(CSR_MODE_CRC32);
      // empty message, then resume with an empty leading request
      send_request(8'h00, 1'b0, 1'b1, 1'b1, 32'h0000_0000, 1'b1);
      send_request(8'h5A, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0);
      send_request(8'h00, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0);
      send_request(8'hFF, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1);
      send_request(8'h80, 1'b1, 1'b1, 1'b0, 32'h0000_0000, 1'b1);
      // switch to CRC-16 mid-message: the running value is cut to 16 bits
      send_request(8'hA5, 1'b1, 1'b1, 1'b1, 32'h1234_5678, 1'b0);
      write_mode(CSR_MODE_CRC16);
      send_request(8'h5A, 1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b1);
      send_request(8'h01, 1'b1, 1'b1, 1'b0, 32'hFFFF_1234, 1'b1);
      send_request(8'h00, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
      send_request(8'hFF, 1'b1, 1'b1, 1'b0, 32'h0000_0000, 1'b1);
      send_request(8'h31, 1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b0);
      write_mode(CSR_MODE_CRC32P4);
      send_request(8'h32, 1'b1, 1'b0, 1'b1, 32'h0000_0000, 1'b1);
      send_request(8'hFF, 1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b1);
      send_request(8'h00, 1'b1, 1'b1, 1'b0, 32'h8000_0001, 1'b1);
      write_mode(CSR_MODE_SPARE);
      send_request(8'h31, 1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b1);
      send_request(8'h7F, 1'b1, 1'b1, 1'b0, 32'hDEAD_BEEF, 1'b1);

      for (seg = 0; seg < SEGMENTS; seg++) begin
         write_mode(segment_mode[seg]);
         // receiver idles more first, then the sender, then neither idles
         req_idle_pct = (seg / 2 == 0) ? 12 : (seg / 2 == 1) ? 46 : 0;
         rsp_idle_pct = (seg / 2 == 0) ? 46 : (seg / 2 == 1) ? 12 : 0;
         target = requests_sent + RANDOM_ITEMS / SEGMENTS;
         while (requests_sent < target) begin
            if ($urandom_range(9) == 0)
               send_request(8'($urandom_range(255)), 1'($urandom_range(1)),
                            1'($urandom_range(1)), 1'($urandom_range(1)),
                            $urandom, 1'($urandom_range(1)));
            else
               send_message();
         end
      end

      wait_idle();
      $display("%0d requests sent, %0d CRC results checked", requests_sent, results_checked);
      $display("modes CRC-32, CRC-32P4, CRC-16 and the spare code, with and without stalls");
      if (fail_count == 0 && pending_results == 0)
         $display("multi_mode_crc_engine: match");
      else
         $display("multi_mode_crc_engine: mismatch");
      $finish;
   end

endmodule

FILE: files.f
design/mmcrc_pkg.sv
design/mmcrc_front.sv
design/mmcrc_fifo.sv
design/mmcrc_back.sv
design/multi_mode_crc_engine.sv
sim/multi_mode_crc_engine_checker.sv
sim/multi_mode_crc_engine_test.sv
